// ===== hdl/rstok_pkg.sv =====
package rstok_pkg;

    localparam logic [4:0] KIND_STRING   = 5'd12;
    localparam logic [4:0] KIND_WORD     = 5'd13;
    localparam logic [4:0] KIND_KEYWORD0 = 5'd14;
    localparam logic [4:0] KIND_END      = 5'd20;
    localparam logic [4:0] KIND_UNKNOWN  = 5'd21;

    localparam int          NUM_SLOTS      = 4;
    localparam int          NUM_KEYWORDS   = 6;
    localparam int          KW_MAX_LEN     = 9;
    localparam logic [5:0]  ALL_CANDIDATES = 6'h3F;

    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{4'd4, 4'd7, 4'd9, 4'd5, 4'd4, 4'd7};

    localparam logic [7:0] KW_TEXT [NUM_KEYWORDS][KW_MAX_LEN] = '{
        '{"d", "o", "n", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "u", "n", "n", "i", "n", "g", 8'h00, 8'h00},
        '{"c", "o", "n", "n", "e", "c", "t", "e", "d"},
        '{"e", "r", "r", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "x", "i", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "o", "p", "p", "e", "d", 8'h00, 8'h00}
    };

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } tok_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] valid;
        tok_t [NUM_SLOTS-1:0] tok;
    } grp_t;

    function automatic logic is_word_byte(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h2D, 8'h5F};
    endfunction

    // punctuation kind, or KIND_UNKNOWN when c is not punctuation
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            "{":     k = 5'd0;
            "}":     k = 5'd1;
            "[":     k = 5'd2;
            "]":     k = 5'd3;
            "=":     k = 5'd4;
            "^":     k = 5'd5;
            "*":     k = 5'd6;
            "+":     k = 5'd7;
            "@":     k = 5'd8;
            "&":     k = 5'd9;
            "~":     k = 5'd10;
            ",":     k = 5'd11;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/rstok_lexer.sv =====
module rstok_lexer
    import rstok_pkg::*;
#(
    parameter int MAX_BUFFER_BYTES = 65536
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] text_byte,
    input  logic       buffer_end,
    output grp_t       group_next
);

    localparam int PW = $clog2(MAX_BUFFER_BYTES);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_STRING = 2'd2;
    localparam logic [1:0] MODE_ESCAPE = 2'd3;

    logic [1:0]    mode_reg, mode_next;
    logic [PW-1:0] pos_reg, pos_next_v;
    logic [PW-1:0] start_reg, start_next;
    logic [5:0]    cand_reg, cand_next;

    logic [1:0]    m1;
    logic [PW-1:0] start1;
    logic [5:0]    cand1;
    logic [PW-1:0] pn;
    logic [PW-1:0] d_cur;
    logic [PW-1:0] midx;
    logic [5:0]    mv;
    logic          wb;
    logic [4:0]    pk;
    logic          do_idle;

    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
        return (p == PW'(MAX_BUFFER_BYTES - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] pos_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (a < b)
        begin
            d = d + (PW+1)'(MAX_BUFFER_BYTES);
        end
        return d[PW-1:0];
    endfunction

    function automatic logic [5:0] kw_match(input logic [7:0] c, input logic [PW-1:0] idx);
        logic [5:0] m;
        logic [3:0] i4;
        logic       in_range;
        in_range = (idx < PW'(KW_MAX_LEN));
        i4 = in_range ? idx[3:0] : 4'd0;
        for (int k = 0; k < NUM_KEYWORDS; k++)
        begin
            m[k] = in_range && (i4 < KW_LEN[k]) && (KW_TEXT[k][i4] == c);
        end
        return m;
    endfunction

    function automatic tok_t word_tok(input logic [PW-1:0] s, input logic [PW-1:0] len,
                                      input logic [5:0] cand);
        tok_t t;
        t.kind   = KIND_WORD;
        t.start  = 16'(s);
        t.length = 16'(len);
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--)
        begin
            if (cand[k] && (len == PW'(KW_LEN[k])))
            begin
                t.kind = KIND_KEYWORD0 + 5'(k);
            end
        end
        return t;
    endfunction

    assign wb    = is_word_byte(text_byte);
    assign pk    = punct_kind(text_byte);
    assign pn    = pos_inc(pos_reg);
    assign d_cur = pos_diff(pos_reg, start_reg);
    assign midx  = (mode_reg == MODE_WORD) ? d_cur : '0;
    assign mv    = kw_match(text_byte, midx);

    always_comb
    begin
        group_next = '0;
        m1         = mode_reg;
        start1     = start_reg;
        cand1      = cand_reg;
        do_idle    = 1'b0;

        case (mode_reg)
            MODE_WORD:
            begin
                if (wb)
                begin
                    cand1 = cand_reg & mv;
                end
                else
                begin
                    group_next.valid[0] = 1'b1;
                    group_next.tok[0]   = word_tok(start_reg, d_cur, cand_reg);
                    do_idle             = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (text_byte == CHAR_QUOTE)
                begin
                    group_next.valid[1]      = 1'b1;
                    group_next.tok[1].kind   = KIND_STRING;
                    group_next.tok[1].start  = 16'(start_reg);
                    group_next.tok[1].length = 16'(d_cur);
                    m1                       = MODE_IDLE;
                end
                else if (text_byte == CHAR_BACKSLASH)
                begin
                    m1 = MODE_ESCAPE;
                end
            end
            MODE_ESCAPE:
            begin
                m1 = MODE_STRING;
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle)
        begin
            m1    = MODE_IDLE;
            cand1 = ALL_CANDIDATES;
            if (text_byte == CHAR_SPACE || text_byte == CHAR_TAB)
            begin
                m1 = MODE_IDLE;
            end
            else if (pk != KIND_UNKNOWN)
            begin
                group_next.valid[1]      = 1'b1;
                group_next.tok[1].kind   = pk;
                group_next.tok[1].start  = 16'(pos_reg);
                group_next.tok[1].length = 16'd1;
            end
            else if (text_byte == CHAR_QUOTE)
            begin
                m1     = MODE_STRING;
                start1 = pn;
            end
            else if (wb)
            begin
                m1     = MODE_WORD;
                start1 = pos_reg;
                cand1  = mv;
            end
            else
            begin
                group_next.valid[1]      = 1'b1;
                group_next.tok[1].kind   = KIND_UNKNOWN;
                group_next.tok[1].start  = 16'(pos_reg);
                group_next.tok[1].length = 16'd1;
            end
        end

        if (buffer_end)
        begin
            if (m1 == MODE_WORD)
            begin
                group_next.valid[2] = 1'b1;
                group_next.tok[2]   = word_tok(start1, pos_diff(pn, start1), cand1);
            end
            group_next.valid[3]      = 1'b1;
            group_next.tok[3].kind   = KIND_END;
            group_next.tok[3].start  = 16'(pn);
            group_next.tok[3].length = 16'd0;
            mode_next  = MODE_IDLE;
            pos_next_v = '0;
            start_next = '0;
            cand_next  = ALL_CANDIDATES;
        end
        else
        begin
            mode_next  = m1;
            pos_next_v = pn;
            start_next = start1;
            cand_next  = cand1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            cand_reg  <= ALL_CANDIDATES;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next_v;
            start_reg <= start_next;
            cand_reg  <= cand_next;
        end
    end

endmodule

// ===== hdl/rstok_outq.sv =====
module rstok_outq
    import rstok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  grp_t        group_next,
    output logic        room,
    output logic        token_valid,
    input  logic        token_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        run_last
);

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    tok_t [NUM_SLOTS-1:0] tok_reg;
    logic [NUM_SLOTS-1:0] lowest;
    logic [NUM_SLOTS-1:0] remain;
    logic                 xfer;
    tok_t                 sel;

    assign lowest      = valid_reg & (~valid_reg + NUM_SLOTS'(1));
    assign remain      = valid_reg & ~lowest;
    assign token_valid = |valid_reg;
    assign xfer        = token_valid & ~token_stall;
    assign room        = (remain == '0) && (!token_valid || !token_stall);
    assign run_last    = (remain == '0);

    always_comb
    begin
        sel = tok_reg[0];
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (lowest[i])
            begin
                sel = tok_reg[i];
            end
        end
    end

    assign token_kind   = sel.kind;
    assign token_start  = sel.start;
    assign token_length = sel.length;

    always_comb
    begin
        if (take)
        begin
            valid_next = group_next.valid;
        end
        else if (xfer)
        begin
            valid_next = remain;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg <= group_next.tok;
        end
    end

endmodule

// ===== hdl/record_stream_tokenizer_unit.sv =====
// Channel   Direction  Handshake                 Payload
// text      in         text_valid / text_stall   text_byte, buffer_end
// token     out        token_valid / token_stall token_kind, token_start, token_length,
//                                                run_last
//
// One byte per cycle is taken while each byte causes at most one token and token_stall is low.
// A byte that causes two or three tokens holds text_stall high while the token
// register drains them, one token per transfer.
// The first token of a transferred byte appears in the cycle after the transfer.
// Reset clears the lexer state and empties the token register; no clearing pass.
// text_stall is high while the token register holds more than its head token,
// or while token_stall holds that head token back.
module record_stream_tokenizer_unit
    import rstok_pkg::*;
#(
    parameter int MAX_BUFFER_BYTES = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_stall,
    input  logic [7:0]  text_byte,
    input  logic        buffer_end,
    output logic        token_valid,
    input  logic        token_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        run_last
);

    grp_t group_next;
    logic room;
    logic take;

    assign text_stall = ~room;
    assign take       = text_valid & room;

    rstok_lexer #(
        .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
    ) u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .text_byte  (text_byte),
        .buffer_end (buffer_end),
        .group_next (group_next)
    );

    rstok_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .group_next   (group_next),
        .room         (room),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .run_last     (run_last)
    );

endmodule
